@@ rtl/easc_pkg.sv @@
// ----------------------------------------------------------------------------
// easc_pkg: shared types and constants for the address syntax checker
// Character codes, length limits and the per-character class bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package easc_pkg;

  // Length limits of the two address parts
  localparam int MAX_LOCAL_LEN   = 64;
  localparam int MAX_DOMAIN_SPAN = 63;

  // Saturating part counters
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Limits as counter-width constants
  localparam logic [CNT_W-1:0] LOCAL_LIMIT  = CNT_W'(MAX_LOCAL_LEN);
  localparam logic [CNT_W-1:0] DOMAIN_LIMIT = CNT_W'(MAX_DOMAIN_SPAN - 1);

  // Character codes
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_DASH = 8'h2D;

  typedef logic [7:0]       char_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Class of one character
  typedef struct packed {
    logic is_at;       // '@'
    logic is_dot;      // '.'
    logic is_basic;    // letter, digit, '.' or '-'
    logic is_special;  // one of !#$%&'*+/=?^_`{|}~
  } char_class_t;

endpackage : easc_pkg

`default_nettype wire

@@ rtl/easc_classify.sv @@
// ----------------------------------------------------------------------------
// easc_classify: character class decoder
// Sort one byte into the classes that the syntax rules test.
// ----------------------------------------------------------------------------
`default_nettype none

module easc_classify (
  input  easc_pkg::char_t       char_code,
  output easc_pkg::char_class_t cls
);
  import easc_pkg::*;

  logic letter;
  logic digit;

  assign letter = (char_code inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  assign digit  = (char_code inside {[8'h30:8'h39]});

  assign cls.is_at      = (char_code == CH_AT);
  assign cls.is_dot     = (char_code == CH_DOT);
  assign cls.is_basic   = letter || digit || (char_code == CH_DOT) || (char_code == CH_DASH);
  // ! # $ % & ' * + / = ? ^ _ ` { | } ~
  assign cls.is_special = (char_code inside {8'h21, [8'h23:8'h27], 8'h2A, 8'h2B, 8'h2F,
                                             8'h3D, 8'h3F, [8'h5E:8'h60], [8'h7B:8'h7E]});

endmodule : easc_classify

`default_nettype wire

@@ rtl/easc_rules.sv @@
// ----------------------------------------------------------------------------
// easc_rules: address state and rule checks
// Hold the per-address state, apply one character per step, and form the
// verdict on the final character.
// ----------------------------------------------------------------------------
`default_nettype none

module easc_rules (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   step,     // one character is consumed
  input  easc_pkg::char_class_t cls,
  input  wire                   is_last,
  output logic                  verdict   // valid only with step && is_last
);
  import easc_pkg::*;

  logic in_domain_r, in_domain_nxt;
  cnt_t local_count_r, local_count_nxt;
  cnt_t domain_count_r, domain_count_nxt;
  logic prev_dot_r, prev_dot_nxt;
  logic failed_r, failed_nxt;

  always_comb begin
    in_domain_nxt    = in_domain_r;
    local_count_nxt  = local_count_r;
    domain_count_nxt = domain_count_r;
    prev_dot_nxt     = prev_dot_r;
    failed_nxt       = failed_r;
    if (!in_domain_r) begin
      if (cls.is_at) begin
        if ((local_count_r == '0) || prev_dot_r) failed_nxt = 1'b1;
        in_domain_nxt = 1'b1;
        prev_dot_nxt  = 1'b0;
      end else begin
        if (!cls.is_basic && !cls.is_special) failed_nxt = 1'b1;
        if (cls.is_dot && ((local_count_r == '0) || prev_dot_r)) failed_nxt = 1'b1;
        prev_dot_nxt    = cls.is_dot;
        local_count_nxt = (local_count_r == CNT_MAX) ? CNT_MAX : local_count_r + cnt_t'(1);
        if (local_count_nxt > LOCAL_LIMIT) failed_nxt = 1'b1;
      end
    end else begin
      if (!cls.is_basic) failed_nxt = 1'b1;
      if (cls.is_dot && ((domain_count_r == '0) || prev_dot_r)) failed_nxt = 1'b1;
      prev_dot_nxt     = cls.is_dot;
      domain_count_nxt = (domain_count_r == CNT_MAX) ? CNT_MAX : domain_count_r + cnt_t'(1);
      if (domain_count_nxt > DOMAIN_LIMIT) failed_nxt = 1'b1;
    end
  end

  assign verdict = !failed_nxt && in_domain_nxt && (domain_count_nxt != '0) && !prev_dot_nxt;

  // Clear all state on reset and after the final character so the next address starts fresh
  always_ff @(posedge clk) begin
    if (!rst_n || (step && is_last)) begin
      in_domain_r    <= 1'b0;
      local_count_r  <= '0;
      domain_count_r <= '0;
      prev_dot_r     <= 1'b0;
      failed_r       <= 1'b0;
    end else if (step) begin
      in_domain_r    <= in_domain_nxt;
      local_count_r  <= local_count_nxt;
      domain_count_r <= domain_count_nxt;
      prev_dot_r     <= prev_dot_nxt;
      failed_r       <= failed_nxt;
    end
  end

endmodule : easc_rules

`default_nettype wire

@@ rtl/email_address_syntax_check.sv @@
// ----------------------------------------------------------------------------
// email_address_syntax_check: streaming address syntax checker
// Check an address one character per beat and report one pass/fail bit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat per character, in_char_code
//   holds the raw byte and in_is_last marks the final character.
//   Result channel (out_valid/out_ready): one beat per address, sent for the
//   beat that carried in_is_last; out_valid_res is 1 when the address passed.
//   Result path: the final character passes the input register, then the
//   result register, which raises out_valid; the receiver takes the result
//   at an edge with out_ready high.
//   Throughput: one character per cycle unless stalled. Rule checks: a byte
//   decode and a 7-bit counter update between input register and state.
//   Stall: while a result waits, characters that are not the final one keep
//   flowing; a final character holds in the input register until the result
//   register frees, and in_ready drops only then.
//   Reset (rst_n low, synchronous): drop both registered beats and return to
//   the start of a new address.
// ----------------------------------------------------------------------------
`default_nettype none

module email_address_syntax_check (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  easc_pkg::char_t  in_char_code,
  input  wire              in_is_last,
  output logic             out_valid,
  input  wire              out_ready,
  output logic             out_valid_res
);
  import easc_pkg::*;

  // Input register
  logic        s1_valid_r;
  char_t       s1_char_r;
  logic        s1_last_r;
  logic        s1_go;

  // Result register
  logic        out_valid_r;
  logic        out_res_r;

  char_class_t cls;
  logic        verdict;

  // Advance the input beat unless it is a final character facing a full,
  // stalled result register.
  assign s1_go    = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_is_last;
    end
  end

  easc_classify u_classify (
    .char_code (s1_char_r),
    .cls       (cls)
  );

  easc_rules u_rules (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_go),
    .cls     (cls),
    .is_last (s1_last_r),
    .verdict (verdict)
  );

  // Load a result on a final character; clear after the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_res_r <= verdict;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_res_r;

endmodule : email_address_syntax_check

`default_nettype wire

@@ rtl/easc_checker.sv @@
// ----------------------------------------------------------------------------
// easc_checker: port-level checks for the address syntax checker
// Watch the top-level handshakes and flag ordering and stall slips.
// ----------------------------------------------------------------------------
`default_nettype none

module easc_checker (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_ready,
  input wire in_is_last,
  input wire out_valid,
  input wire out_ready,
  input wire out_valid_res
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_valid_res))
    else $error("result beat changed while stalled");

  // Reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A new result follows an accepted final character
  a_rise_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_is_last, 2))
    else $error("result without a final character");

  // A ready receiver never blocks the input side
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while the receiver is ready");

endmodule : easc_checker

bind email_address_syntax_check easc_checker u_easc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_is_last    (in_is_last),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_valid_res (out_valid_res)
);

`default_nettype wire
